// File: hw/rtl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// RST polynomial controller package
// Widths, register indexes, operation codes and the command and status
// records shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

   // Highest delay power of the R, S and T polynomials.
   localparam int MAX_ORDER = 4;
   localparam int DEPTH     = MAX_ORDER + 1;
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Field widths of the channels and registers.
   localparam int DATA_W       = 32;
   localparam int FRAC_W       = 16;
   localparam int ACC_W        = 2 * DATA_W;
   localparam int PART_W       = ACC_W - FRAC_W;
   localparam int ORDER_W      = 3;
   localparam int BAND_W       = 31;
   localparam int COEF_TABLE_W = 2;
   localparam int COEF_INDEX_W = 3;
   localparam int CSR_INDEX_W  = 3;

   // Operation codes of an input item.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   // Coefficient table selectors of a load item.
   localparam logic [COEF_TABLE_W-1:0] TBL_R = 2'd0;
   localparam logic [COEF_TABLE_W-1:0] TBL_S = 2'd1;
   localparam logic [COEF_TABLE_W-1:0] TBL_T = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_ORDER    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_MIN       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_MAX       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_DEAD_BAND = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_DEAD_BAND = 3'd4;

   // Operand pair fed to the shared multiplier.
   typedef enum logic [1:0] {
      SEL_T,
      SEL_R,
      SEL_S
   } rpc_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             take_sample;
      logic             load_coef;
      logic             mul_en;
      rpc_sel_type      sel;
      logic [IDX_W-1:0] idx;
      logic             dead_check;
      logic             limit;
      logic             publish;
   } rpc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [IDX_W-1:0] order;
      logic             out_free;
   } rpc_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/rpc_req_if.sv
// ----------------------------------------------------------------------------
// RST controller request channel
// Valid/ready channel carrying control samples and coefficient loads.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpc_req_if import rpc_pkg::*; ();

   logic                           valid;
   logic                           ready;
   logic                           op;
   logic signed [DATA_W-1:0]       reference;
   logic signed [DATA_W-1:0]       measurement;
   logic        [COEF_TABLE_W-1:0] coef_table;
   logic        [COEF_INDEX_W-1:0] coef_index;
   logic signed [DATA_W-1:0]       coef_value;

   modport source (
      output valid, op, reference, measurement, coef_table, coef_index, coef_value,
      input  ready
   );

   modport sink (
      input  valid, op, reference, measurement, coef_table, coef_index, coef_value,
      output ready
   );

endinterface

`default_nettype wire

// File: hw/rtl/rpc_rsp_if.sv
// ----------------------------------------------------------------------------
// RST controller response channel
// Valid/ready channel carrying the clamped control drive.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpc_rsp_if import rpc_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] control;
   logic                     clamped;

   modport source (
      output valid, control, clamped,
      input  ready
   );

   modport sink (
      input  valid, control, clamped,
      output ready
   );

endinterface

`default_nettype wire

// File: hw/rtl/rpc_controller.sv
// ----------------------------------------------------------------------------
// RST controller sequencer
// State machine that steps the shared multiply-accumulate through the
// T/R terms, the dead-zone test, the S terms, the clamp and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_controller import rpc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_op,
   output logic           req_ready,
   input  rpc_status_type status,
   output rpc_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC_TR,
      ST_DRAIN_TR,
      ST_DEAD,
      ST_MAC_S,
      ST_DRAIN_S,
      ST_LIMIT,
      ST_OUTPUT
   } state_type;

   state_type        state_ff, state_in;
   rpc_sel_type      sel_ff, sel_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             accept;
   logic             take;

   // Items are taken only while idle and never during reset.
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign take      = accept && (req_op == OP_SAMPLE);

   // Next state and operand index.
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = ST_MAC_TR;
               sel_in   = SEL_T;
               idx_in   = '0;
            end
         end
         ST_MAC_TR: begin
            // T and R terms alternate at each delay power.
            if (sel_ff == SEL_T) begin
               sel_in = SEL_R;
            end else if (idx_ff == status.order) begin
               state_in = ST_DRAIN_TR;
            end else begin
               sel_in = SEL_T;
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN_TR: begin
            state_in = ST_DEAD;
         end
         ST_DEAD: begin
            if (status.order == '0) begin
               state_in = ST_LIMIT;
            end else begin
               state_in = ST_MAC_S;
               sel_in   = SEL_S;
               idx_in   = IDX_W'(1);
            end
         end
         ST_MAC_S: begin
            if (idx_ff == status.order) begin
               state_in = ST_DRAIN_S;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN_S: begin
            state_in = ST_LIMIT;
         end
         ST_LIMIT: begin
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered operand selection.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SEL_T;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         idx_ff   <= idx_in;
      end
   end

   // Command decode for the datapath.
   always_comb begin
      cmd.take_sample = take;
      cmd.load_coef   = accept && (req_op == OP_LOAD);
      cmd.mul_en      = (state_ff == ST_MAC_TR) || (state_ff == ST_MAC_S);
      cmd.sel         = sel_ff;
      cmd.idx         = idx_ff;
      cmd.dead_check  = (state_ff == ST_DEAD);
      cmd.limit       = (state_ff == ST_LIMIT);
      cmd.publish     = (state_ff == ST_OUTPUT) && status.out_free;
   end

endmodule

`default_nettype wire

// File: hw/rtl/rpc_datapath.sv
// ----------------------------------------------------------------------------
// RST controller datapath
// Registers, histories, coefficient tables, shared multiply-accumulate,
// dead-zone test, clamp and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_datapath import rpc_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  rpc_cmd_type                    cmd,
   output rpc_status_type                 status,
   input  logic signed [DATA_W-1:0]       req_reference,
   input  logic signed [DATA_W-1:0]       req_measurement,
   input  logic        [COEF_TABLE_W-1:0] req_coef_table,
   input  logic        [COEF_INDEX_W-1:0] req_coef_index,
   input  logic signed [DATA_W-1:0]       req_coef_value,
   input  logic                           csr_write_enable,
   input  logic        [CSR_INDEX_W-1:0]  csr_index,
   input  logic        [DATA_W-1:0]       csr_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [DATA_W-1:0]       rsp_control,
   output logic                           rsp_clamped
);

   // Configuration registers.
   logic        [ORDER_W-1:0] filter_order_ff;
   logic signed [DATA_W-1:0]  drive_min_ff;
   logic signed [DATA_W-1:0]  drive_max_ff;
   logic        [BAND_W-1:0]  error_band_ff;
   logic        [BAND_W-1:0]  drive_band_ff;

   // Histories and coefficient tables.
   logic signed [DATA_W-1:0] ref_hist_ff  [DEPTH];
   logic signed [DATA_W-1:0] meas_hist_ff [DEPTH];
   logic signed [DATA_W-1:0] ctl_hist_ff  [DEPTH];
   logic signed [DATA_W-1:0] r_coef_ff    [DEPTH];
   logic signed [DATA_W-1:0] s_coef_ff    [DEPTH];
   logic signed [DATA_W-1:0] t_coef_ff    [DEPTH];

   logic [IDX_W-1:0]         order_eff;
   logic [IDX_W-1:0]         coef_addr;
   logic                     coef_addr_ok;

   // Multiply-accumulate.
   logic signed [DATA_W-1:0] coef_op;
   logic signed [DATA_W-1:0] data_op;
   logic signed [ACC_W-1:0]  product_in, product_ff;
   logic                     prod_valid_ff;
   logic                     prod_sub_ff;
   logic signed [ACC_W-1:0]  acc_in, acc_ff;
   logic signed [PART_W-1:0] acc_q;

   // Dead-zone test.
   logic signed [DATA_W:0]   err_diff;
   logic        [DATA_W:0]   err_mag;
   logic                     err_small_in, err_small_ff;
   logic        [PART_W-1:0] part_mag;
   logic                     dead_zone;

   // Clamp and output.
   logic signed [PART_W-1:0] max_ext;
   logic signed [PART_W-1:0] min_ext;
   logic                     gt_hi_ff;
   logic                     lt_lo_ff;
   logic signed [DATA_W-1:0] result_in;
   logic                     rsp_valid_in, rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_control_ff;
   logic                     rsp_clamped_ff;

   // Configuration writes; an unknown index does nothing.
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_order_ff <= '0;
         drive_min_ff    <= '0;
         drive_max_ff    <= '0;
         error_band_ff   <= '0;
         drive_band_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FILTER_ORDER:    filter_order_ff <= csr_write_data[ORDER_W-1:0];
            CSR_DRIVE_MIN:       drive_min_ff    <= $signed(csr_write_data);
            CSR_DRIVE_MAX:       drive_max_ff    <= $signed(csr_write_data);
            CSR_ERROR_DEAD_BAND: error_band_ff   <= csr_write_data[BAND_W-1:0];
            CSR_DRIVE_DEAD_BAND: drive_band_ff   <= csr_write_data[BAND_W-1:0];
            default: ;
         endcase
      end
   end

   // An order above MAX_ORDER behaves as the largest order.
   always_comb begin
      if (int'(filter_order_ff) > MAX_ORDER) begin
         order_eff = IDX_W'(MAX_ORDER);
      end else begin
         order_eff = IDX_W'(filter_order_ff);
      end
   end

   assign coef_addr    = IDX_W'(req_coef_index);
   assign coef_addr_ok = int'(req_coef_index) <= MAX_ORDER;

   // Coefficient loads; a bad table or index leaves the tables untouched.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            r_coef_ff[i] <= '0;
            s_coef_ff[i] <= '0;
            t_coef_ff[i] <= '0;
         end
      end else if (cmd.load_coef && coef_addr_ok) begin
         case (req_coef_table)
            TBL_R:   r_coef_ff[coef_addr] <= req_coef_value;
            TBL_S:   s_coef_ff[coef_addr] <= req_coef_value;
            TBL_T:   t_coef_ff[coef_addr] <= req_coef_value;
            default: ;
         endcase
      end
   end

   // Histories shift up to the active order on a sample and clear on a load.
   always_ff @(posedge clock) begin
      if (reset || cmd.load_coef) begin
         for (int i = 0; i < DEPTH; i++) begin
            ref_hist_ff[i]  <= '0;
            meas_hist_ff[i] <= '0;
            ctl_hist_ff[i]  <= '0;
         end
      end else if (cmd.take_sample) begin
         ref_hist_ff[0]  <= req_reference;
         meas_hist_ff[0] <= req_measurement;
         for (int i = 1; i < DEPTH; i++) begin
            if (i <= int'(order_eff)) begin
               ref_hist_ff[i]  <= ref_hist_ff[i-1];
               meas_hist_ff[i] <= meas_hist_ff[i-1];
               ctl_hist_ff[i]  <= ctl_hist_ff[i-1];
            end
         end
      end else if (cmd.publish) begin
         ctl_hist_ff[0] <= result_in;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (cmd.sel)
         SEL_T: begin
            coef_op = t_coef_ff[cmd.idx];
            data_op = ref_hist_ff[cmd.idx];
         end
         SEL_R: begin
            coef_op = r_coef_ff[cmd.idx];
            data_op = meas_hist_ff[cmd.idx];
         end
         SEL_S: begin
            coef_op = s_coef_ff[cmd.idx];
            data_op = ctl_hist_ff[cmd.idx];
         end
         default: begin
            coef_op = '0;
            data_op = '0;
         end
      endcase
   end

   // Exact Q32.32 product, registered before the accumulator.
   assign product_in = coef_op * data_op;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         product_ff  <= product_in;
         prod_sub_ff <= (cmd.sel != SEL_T);
      end
   end

   // Accumulator wraps modulo 2^64; the dead zone forces it to zero.
   always_comb begin
      acc_in = acc_ff;
      if (cmd.take_sample) begin
         acc_in = '0;
      end else if (cmd.dead_check && dead_zone) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         if (prod_sub_ff) begin
            acc_in = acc_ff - product_ff;
         end else begin
            acc_in = acc_ff + product_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         acc_ff        <= '0;
      end else begin
         prod_valid_ff <= cmd.mul_en;
         acc_ff        <= acc_in;
      end
   end

   // Arithmetic shift of the accumulator back to Q32.16, keeping all integer bits.
   assign acc_q = $signed(acc_ff[ACC_W-1:FRAC_W]);

   // Tracking error is taken exactly at sample time.
   assign err_diff     = {req_reference[DATA_W-1], req_reference}
                       - {req_measurement[DATA_W-1], req_measurement};
   assign err_mag      = err_diff[DATA_W] ? (~err_diff + 1'b1) : err_diff;
   assign err_small_in = err_mag < (DATA_W+1)'(error_band_ff);

   always_ff @(posedge clock) begin
      if (cmd.take_sample) begin
         err_small_ff <= err_small_in;
      end
   end

   // Dead zone: small error, small partial drive and an unchanged reference.
   assign part_mag  = acc_q[PART_W-1] ? PART_W'(~acc_q + 1'b1) : PART_W'(acc_q);
   assign dead_zone = err_small_ff
                   && (part_mag < PART_W'(drive_band_ff))
                   && (ref_hist_ff[0] == ref_hist_ff[1]);

   // Limits are compared before narrowing, so overflow is caught as well.
   assign max_ext = $signed({{(PART_W-DATA_W){drive_max_ff[DATA_W-1]}}, drive_max_ff});
   assign min_ext = $signed({{(PART_W-DATA_W){drive_min_ff[DATA_W-1]}}, drive_min_ff});

   always_ff @(posedge clock) begin
      if (cmd.limit) begin
         gt_hi_ff <= acc_q > max_ext;
         lt_lo_ff <= acc_q < min_ext;
      end
   end

   // The upper limit takes precedence when the limits are inverted.
   always_comb begin
      if (gt_hi_ff) begin
         result_in = drive_max_ff;
      end else if (lt_lo_ff) begin
         result_in = drive_min_ff;
      end else begin
         result_in = acc_q[DATA_W-1:0];
      end
   end

   // Output register holds a result until it is taken.
   assign rsp_valid_in = cmd.publish || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_control_ff <= result_in;
         rsp_clamped_ff <= gt_hi_ff || lt_lo_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_control = rsp_control_ff;
   assign rsp_clamped = rsp_clamped_ff;

   assign status.order    = order_eff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

// File: hw/rtl/rst_polynomial_controller.sv
// ----------------------------------------------------------------------------
// RST polynomial controller
// Fixed-point RST control law with dead zone and output clamp, built as a
// sequencer driving one shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Carries
//   req_chan  in         valid/ready    op, reference, measurement, coefficient
//   rsp_chan  out        valid/ready    control, clamped
//   csr_*     in         write enable   index, write data
//
// A control sample keeps the block busy until its result is published, as
// the shared 32x32 multiplier takes one product per cycle through its terms.
// A load item is taken without leaving the idle state.
// Reset is synchronous and clears registers, histories and coefficients.
// A result waits in the output register while the next item is accepted;
// a following result is held back until that register has been emptied.
//
`default_nettype none

module rst_polynomial_controller import rpc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   rpc_req_if.sink                req_chan,
   rpc_rsp_if.source              rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_write_data
);

   rpc_cmd_type    cmd;
   rpc_status_type status;
   logic           req_ready;

   // Sequencer.
   rpc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // Arithmetic and storage.
   rpc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_reference    (req_chan.reference),
      .req_measurement  (req_chan.measurement),
      .req_coef_table   (req_chan.coef_table),
      .req_coef_index   (req_chan.coef_index),
      .req_coef_value   (req_chan.coef_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_control      (rsp_chan.control),
      .rsp_clamped      (rsp_chan.clamped)
   );

endmodule

`default_nettype wire

// File: hw/rtl/rpc_checker.sv
// ----------------------------------------------------------------------------
// RST controller port checks
// Assertions on the top-level ports, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_checker import rpc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_op,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_control,
   input logic              rsp_clamped
);

   // A stalled result stays put with its payload unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_control) && $stable(rsp_clamped)))
      else $error("stalled result changed or dropped");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result present after reset");

   // A control sample occupies the sequencer, so no item follows at once.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_op == OP_SAMPLE)) |=> !req_ready)
      else $error("item accepted while a sample is being worked on");

   // No result can appear in the cycle straight after an acceptance.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind rst_polynomial_controller rpc_checker u_rpc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_op      (req_chan.op),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_control (rsp_chan.control),
   .rsp_clamped (rsp_chan.clamped)
);

`default_nettype wire

// File: test/rst_polynomial_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RST polynomial controller testbench
// Drives control samples and coefficient loads through the request channel,
// changes the configuration between phases while the block is idle, and
// checks every control drive against an independent fixed-point predictor.
// Both channels idle and stall at random, with calm stretches in between.
// ----------------------------------------------------------------------------

module rst_polynomial_controller_tb;
   import rpc_pkg::*;

   localparam int unsigned LIMIT_CYCLES  = 500000;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned PHASES        = 10;
   localparam int unsigned PHASE_ITEMS   = 120;
   localparam int          Q_ONE         = 1 << FRAC_W;

   localparam logic signed [DATA_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] Q_MIN  = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] Q_HALF = 32'sh0000_8000;
   localparam logic [COEF_TABLE_W-1:0]  TBL_NONE = 2'd3;

   typedef struct packed {
      logic                           op;
      logic signed [DATA_W-1:0]       reference;
      logic signed [DATA_W-1:0]       measurement;
      logic        [COEF_TABLE_W-1:0] coef_table;
      logic        [COEF_INDEX_W-1:0] coef_index;
      logic signed [DATA_W-1:0]       coef_value;
   } ctl_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] control;
      logic                     clamped;
   } drive_result_type;

   // Predictor of the control law and store of the drives still to arrive.
   class drive_scoreboard;
      logic signed [DATA_W-1:0] ref_hist[DEPTH];
      logic signed [DATA_W-1:0] meas_hist[DEPTH];
      logic signed [DATA_W-1:0] drive_hist[DEPTH];
      logic signed [DATA_W-1:0] r_coef[DEPTH];
      logic signed [DATA_W-1:0] s_coef[DEPTH];
      logic signed [DATA_W-1:0] t_coef[DEPTH];
      logic        [ORDER_W-1:0] order_reg;
      logic signed [DATA_W-1:0] lower_limit;
      logic signed [DATA_W-1:0] upper_limit;
      logic        [BAND_W-1:0] error_band;
      logic        [BAND_W-1:0] drive_band;
      drive_result_type         pending_drives[$];
      int unsigned              drive_faults;

      function new();
         clear_histories();
         foreach (r_coef[i]) begin
            r_coef[i] = '0;
            s_coef[i] = '0;
            t_coef[i] = '0;
         end
         order_reg    = '0;
         lower_limit  = '0;
         upper_limit  = '0;
         error_band   = '0;
         drive_band   = '0;
         drive_faults = 0;
      endfunction

      function void clear_histories();
         foreach (ref_hist[i]) begin
            ref_hist[i]   = '0;
            meas_hist[i]  = '0;
            drive_hist[i] = '0;
         end
      endfunction

      function int unsigned pending();
         return pending_drives.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [DATA_W-1:0] data);
         case (index)
            CSR_FILTER_ORDER:    order_reg   = data[ORDER_W-1:0];
            CSR_DRIVE_MIN:       lower_limit = data;
            CSR_DRIVE_MAX:       upper_limit = data;
            CSR_ERROR_DEAD_BAND: error_band  = data[BAND_W-1:0];
            CSR_DRIVE_DEAD_BAND: drive_band  = data[BAND_W-1:0];
            default: ;
         endcase
      endfunction

      // Works out the drive caused by an accepted item, if any.
      function void predict_drive(ctl_item_type it);
         int               n;
         int               i;
         longint           acc;
         longint           err;
         longint           part;
         longint           val;
         drive_result_type res;

         // A load writes one coefficient (bad addresses are dropped) and
         // always clears the histories.
         if (it.op == OP_LOAD) begin
            if (it.coef_index <= MAX_ORDER) begin
               case (it.coef_table)
                  TBL_R: r_coef[it.coef_index] = it.coef_value;
                  TBL_S: s_coef[it.coef_index] = it.coef_value;
                  TBL_T: t_coef[it.coef_index] = it.coef_value;
                  default: ;
               endcase
            end
            clear_histories();
            return;
         end

         // Shift the histories up to the active order, which saturates.
         n = (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
         for (i = n; i >= 1; i--) begin
            ref_hist[i]   = ref_hist[i-1];
            meas_hist[i]  = meas_hist[i-1];
            drive_hist[i] = drive_hist[i-1];
         end
         ref_hist[0]  = it.reference;
         meas_hist[0] = it.measurement;

         acc = 0;
         for (i = 0; i <= n; i++) begin
            acc += longint'(t_coef[i]) * longint'(ref_hist[i]);
            acc -= longint'(r_coef[i]) * longint'(meas_hist[i]);
         end

         // Dead zone: small error, small partial drive and a steady setpoint.
         err = longint'(it.reference) - longint'(it.measurement);
         if (err < 0)
            err = -err;
         part = acc >>> FRAC_W;
         if (part < 0)
            part = -part;
         if (err < longint'(error_band) && part < longint'(drive_band) &&
             ref_hist[0] == ref_hist[1])
            acc = 0;

         for (i = 1; i <= n; i++)
            acc -= longint'(s_coef[i]) * longint'(drive_hist[i]);

         // The upper limit is tested first, so inverted limits give the maximum.
         val         = acc >>> FRAC_W;
         res.clamped = 1'b0;
         if (val > longint'(upper_limit)) begin
            val         = longint'(upper_limit);
            res.clamped = 1'b1;
         end else if (val < longint'(lower_limit)) begin
            val         = longint'(lower_limit);
            res.clamped = 1'b1;
         end
         drive_hist[0] = DATA_W'(val);
         res.control   = drive_hist[0];
         pending_drives.push_back(res);
      endfunction

      // Compares an accepted drive with the oldest prediction.
      function void check_drive(drive_result_type got);
         drive_result_type want;

         if (pending_drives.size() == 0) begin
            $display("%0t: unexpected drive: expected none, actual control %h clamped %b",
                     $time, got.control, got.clamped);
            drive_faults++;
            return;
         end
         want = pending_drives.pop_front();
         if (got.control !== want.control) begin
            $display("%0t: control mismatch: expected %h, actual %h",
                     $time, want.control, got.control);
            drive_faults++;
         end
         if (got.clamped !== want.clamped) begin
            $display("%0t: clamped mismatch: expected %b, actual %b",
                     $time, want.clamped, got.clamped);
            drive_faults++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DATA_W-1:0]      csr_write_data;
   int unsigned            cycles = 0;
   bit                     sender_calm;
   bit                     receiver_calm;
   drive_scoreboard        sb = new();

   rpc_req_if req_chan ();
   rpc_rsp_if rsp_chan ();

   rst_polynomial_controller u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Wait drawn before each item on either side; calm stretches have none.
   function automatic int unsigned draw_wait(bit calm);
      if (calm || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, 18);
   endfunction

   // Q16.16 value: mostly small, sometimes anything, sometimes an extreme.
   function automatic logic signed [DATA_W-1:0] rand_q();
      int v;
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
         1, 2, 3: return $urandom;
         default: begin
            v = $urandom_range(0, 1 << 19);
            return v - (1 << 18);
         end
      endcase
   endfunction

   // Coefficient: mostly within plus or minus one.
   function automatic logic signed [DATA_W-1:0] rand_coef();
      int v;
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
         1: return $urandom;
         default: begin
            v = $urandom_range(0, 2 * Q_ONE);
            return v - Q_ONE;
         end
      endcase
   endfunction

   // Item builders; the fields that the operation ignores are random.
   function automatic ctl_item_type make_sample(logic signed [DATA_W-1:0] r,
                                                logic signed [DATA_W-1:0] m);
      ctl_item_type it;
      it.op          = OP_SAMPLE;
      it.reference   = r;
      it.measurement = m;
      it.coef_table  = COEF_TABLE_W'($urandom);
      it.coef_index  = COEF_INDEX_W'($urandom);
      it.coef_value  = $urandom;
      return it;
   endfunction

   function automatic ctl_item_type make_load(logic [COEF_TABLE_W-1:0] tbl,
                                              logic [COEF_INDEX_W-1:0] idx,
                                              logic signed [DATA_W-1:0] value);
      ctl_item_type it;
      it.op          = OP_LOAD;
      it.reference   = $urandom;
      it.measurement = $urandom;
      it.coef_table  = tbl;
      it.coef_index  = idx;
      it.coef_value  = value;
      return it;
   endfunction

   // Offers one item and notes it once accepted. Ready is sampled on the
   // falling edge so the decision does not race the rising edge.
   task automatic send(ctl_item_type it);
      int unsigned gap;
      logic        took;
      gap = draw_wait(sender_calm);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.op          <= it.op;
      req_chan.reference   <= it.reference;
      req_chan.measurement <= it.measurement;
      req_chan.coef_table  <= it.coef_table;
      req_chan.coef_index  <= it.coef_index;
      req_chan.coef_value  <= it.coef_value;
      do begin
         @(negedge clock);
         took = req_chan.ready;
         @(posedge clock);
      end while (took !== 1'b1);
      sb.predict_drive(it);
   endtask

   // Writes one register; the enable drops for a cycle between writes.
   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.write_reg(index, data);
      @(posedge clock);
   endtask

   // Holds the sender until every drive has come and the block has settled.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: random stalls, checks each accepted drive.
   initial begin : drive_receiver
      int unsigned      stall;
      logic             took;
      drive_result_type got;
      rsp_chan.ready <= 1'b0;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         stall = draw_wait(receiver_calm);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do begin
            @(negedge clock);
            took        = rsp_chan.valid;
            got.control = rsp_chan.control;
            got.clamped = rsp_chan.clamped;
            @(posedge clock);
         end while (took !== 1'b1);
         sb.check_drive(got);
      end
   end

   // Main sequence: reset, directed items, then randomised phases.
   initial begin : stimulus
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] r;
      logic signed [DATA_W-1:0] m;
      logic signed [DATA_W-1:0] lo;
      logic signed [DATA_W-1:0] hi;
      logic [DATA_W-1:0]        err_band;
      logic [DATA_W-1:0]        drv_band;
      logic [COEF_TABLE_W-1:0]  tbl;
      logic signed [DATA_W-1:0] last_ref;
      int                       idx;
      int                       delta;
      int unsigned              n;
      int unsigned              phase;

      reset                <= 1'b1;
      csr_write_enable     <= 1'b0;
      csr_index            <= '0;
      csr_write_data       <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.op          <= OP_SAMPLE;
      req_chan.reference   <= '0;
      req_chan.measurement <= '0;
      req_chan.coef_table  <= TBL_R;
      req_chan.coef_index  <= '0;
      req_chan.coef_value  <= '0;
      sender_calm          = 1'b0;
      receiver_calm        = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: full range, unit dead bands, highest order.
      csr_write(CSR_FILTER_ORDER, MAX_ORDER);
      csr_write(CSR_DRIVE_MIN, Q_MIN);
      csr_write(CSR_DRIVE_MAX, Q_MAX);
      csr_write(CSR_ERROR_DEAD_BAND, Q_ONE);
      csr_write(CSR_DRIVE_DEAD_BAND, Q_ONE);

      send(make_load(TBL_T, COEF_INDEX_W'(0), Q_ONE));
      send(make_load(TBL_R, COEF_INDEX_W'(0), Q_ONE));
      send(make_load(TBL_S, COEF_INDEX_W'(1), Q_HALF));
      a = 32'sh0003_2000;
      send(make_sample(0, 0));
      send(make_sample(a, a + 256));
      // Same setpoint, small error: the dead zone applies.
      send(make_sample(a, a + 256));
      send(make_sample(a, a));
      // Setpoint moves: no dead zone.
      send(make_sample(-a, -a - 256));

      // Extreme coefficients at the deepest delay; bad addresses are dropped.
      send(make_load(TBL_T, COEF_INDEX_W'(MAX_ORDER), Q_MIN));
      send(make_load(TBL_R, COEF_INDEX_W'(MAX_ORDER), Q_MAX));
      send(make_load(TBL_NONE, COEF_INDEX_W'(0), Q_MAX));
      send(make_load(TBL_S, COEF_INDEX_W'(MAX_ORDER + 3), Q_MIN));
      send(make_sample(Q_MAX, Q_MIN));
      send(make_sample(Q_MIN, Q_MAX));
      send(make_sample(Q_MAX, Q_MAX));
      send(make_sample(0, 0));
      send(make_sample(0, 0));
      send(make_sample(Q_MIN, Q_MIN));

      // Random phases, each with its own register settings.
      last_ref = '0;
      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         sender_calm   = ($urandom_range(0, 3) == 0);
         receiver_calm = ($urandom_range(0, 3) == 0);

         case (phase % 4)
            0: begin
               lo = Q_MIN;
               hi = Q_MAX;
            end
            1: begin
               lo = -$signed($urandom_range(0, 8 * Q_ONE));
               hi = $urandom_range(0, 8 * Q_ONE);
            end
            2: begin
               // Inverted limits.
               lo = $urandom_range(1, 4 * Q_ONE);
               hi = -$signed($urandom_range(0, 4 * Q_ONE));
            end
            default: begin
               lo = rand_q();
               hi = lo;
            end
         endcase
         case (phase % 3)
            0: begin
               err_band = '0;
               drv_band = '0;
            end
            1: begin
               err_band = $urandom_range(0, 1 << 20);
               drv_band = $urandom_range(0, 1 << 20);
            end
            default: begin
               // The top bit is beyond the register and must be dropped.
               err_band = $urandom_range(0, 1) ? '1 : $urandom;
               drv_band = $urandom_range(0, 1) ? '1 : $urandom;
            end
         endcase

         csr_write(CSR_FILTER_ORDER, (phase < 8) ? phase : $urandom_range(0, 7));
         csr_write(CSR_DRIVE_MIN, lo);
         csr_write(CSR_DRIVE_MAX, hi);
         csr_write(CSR_ERROR_DEAD_BAND, err_band);
         csr_write(CSR_DRIVE_DEAD_BAND, drv_band);
         csr_write(CSR_DRIVE_DEAD_BAND + CSR_INDEX_W'($urandom_range(1, 3)), $urandom);

         // Fresh coefficients in some phases; otherwise histories carry over.
         if (phase == 0 || $urandom_range(0, 1) == 1) begin
            for (tbl = TBL_R; tbl <= TBL_T; tbl++)
               for (idx = 0; idx <= MAX_ORDER; idx++)
                  if ($urandom_range(0, 2) != 0)
                     send(make_load(tbl, COEF_INDEX_W'(idx), rand_coef()));
         end

         n = 0;
         while (n < PHASE_ITEMS) begin
            case ($urandom_range(0, 99))
               0, 1, 2: drain();
               3, 4, 5, 6, 7: begin
                  send(make_load(COEF_TABLE_W'($urandom), COEF_INDEX_W'($urandom),
                                 rand_coef()));
                  n++;
               end
               default: begin
                  // Steady setpoints and near-tracking measurements reach the
                  // dead zone; the rest is anything.
                  if ($urandom_range(0, 9) < 4)
                     r = last_ref;
                  else
                     r = rand_q();
                  last_ref = r;
                  if ($urandom_range(0, 1) == 1) begin
                     delta = $urandom_range(0, 1 << 13);
                     m     = r + delta - (1 << 12);
                  end else begin
                     m = rand_q();
                  end
                  send(make_sample(r, m));
                  n++;
               end
            endcase
         end
      end

      drain();
      if (sb.drive_faults == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/rpc_pkg.sv
hw/rtl/rpc_req_if.sv
hw/rtl/rpc_rsp_if.sv
hw/rtl/rpc_controller.sv
hw/rtl/rpc_datapath.sv
hw/rtl/rst_polynomial_controller.sv
hw/rtl/rpc_checker.sv
test/rst_polynomial_controller_tb.sv
